/* rtl/core/avt_pkg.sv */
// ----------------------------------------------------------------------------
// avt_pkg
// Shared types and constants for the affine vertex transform.
// ----------------------------------------------------------------------------
package avt_pkg;

   localparam int ROWS   = 3;
   localparam int COLS   = 4;
   localparam int DATA_W = 32;
   localparam int PROD_W = 2 * DATA_W;
   // three full products plus the translation term need two guard bits
   localparam int SUM_W  = PROD_W + 2;

   typedef enum logic {
      CMD_WRITE     = 1'b0,
      CMD_TRANSFORM = 1'b1
   } command_type;

   typedef struct packed {
      command_type        command;
      logic [1:0]         row;
      logic [1:0]         column;
      logic signed [31:0] element_value;
      logic signed [31:0] x_in;
      logic signed [31:0] y_in;
      logic signed [31:0] z_in;
   } req_type;

   typedef struct packed {
      logic signed [31:0] x_out;
      logic signed [31:0] y_out;
      logic signed [31:0] z_out;
   } rsp_type;

   typedef logic signed [DATA_W-1:0] elem_type;
   typedef elem_type [COLS-1:0]      mrow_type;

   // stage load strobes from the pipeline control
   typedef struct packed {
      logic prod_load;
      logic sum_load;
   } lane_ctrl_type;

endpackage

/* rtl/core/avt_lane.sv */
// ----------------------------------------------------------------------------
// avt_lane
// One matrix row: three products in parallel, then the row sum with the
// translation term scaled by one.
// ----------------------------------------------------------------------------
module avt_lane import avt_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                    clock,
   input  lane_ctrl_type           ctrl,
   input  mrow_type                mrow,
   input  logic signed [31:0]      x_in,
   input  logic signed [31:0]      y_in,
   input  logic signed [31:0]      z_in,
   output logic signed [SUM_W-1:0] sum
);

   logic signed [PROD_W-1:0] px_in, py_in, pz_in;
   logic signed [PROD_W-1:0] px_ff, py_ff, pz_ff;
   elem_type                 tr_ff;
   logic signed [SUM_W-1:0]  tr_scaled;
   logic signed [SUM_W-1:0]  sum_in, sum_ff;

   assign px_in = mrow[0] * x_in;
   assign py_in = mrow[1] * y_in;
   assign pz_in = mrow[2] * z_in;

   always_ff @(posedge clock) begin
      if (ctrl.prod_load) begin
         px_ff <= px_in;
         py_ff <= py_in;
         pz_ff <= pz_in;
         tr_ff <= mrow[3];
      end
      if (ctrl.sum_load) begin
         sum_ff <= sum_in;
      end
   end

   assign tr_scaled = $signed({{(SUM_W-DATA_W){tr_ff[DATA_W-1]}}, tr_ff}) <<< FRAC_BITS;

   assign sum_in = $signed({{(SUM_W-PROD_W){px_ff[PROD_W-1]}}, px_ff})
                 + $signed({{(SUM_W-PROD_W){py_ff[PROD_W-1]}}, py_ff})
                 + $signed({{(SUM_W-PROD_W){pz_ff[PROD_W-1]}}, pz_ff})
                 + tr_scaled;

   assign sum = sum_ff;

endmodule

/* rtl/core/avt_merge.sv */
// ----------------------------------------------------------------------------
// avt_merge
// Scales the three row sums back to the input format, saturates each and
// holds the result transaction in the output register.
// ----------------------------------------------------------------------------
module avt_merge import avt_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    load,
   input  logic signed [SUM_W-1:0] sum [ROWS],
   output rsp_type                 rsp
);

   function automatic logic signed [31:0] scale_sat(input logic signed [SUM_W-1:0] s);
      logic signed [SUM_W-1:0] sh;
      logic signed [31:0]      r;
      sh = s >>> FRAC_BITS;
      if ((&sh[SUM_W-1:DATA_W-1]) || !(|sh[SUM_W-1:DATA_W-1])) begin
         r = sh[DATA_W-1:0];
      end else if (sh[SUM_W-1]) begin
         r = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(DATA_W-1){1'b1}}};
      end
      return r;
   endfunction

   rsp_type rsp_in, rsp_ff;

   always_comb begin
      rsp_in.x_out = scale_sat(sum[0]);
      rsp_in.y_out = scale_sat(sum[1]);
      rsp_in.z_out = scale_sat(sum[2]);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

/* rtl/core/affine_vertex_transform.sv */
// ----------------------------------------------------------------------------
// affine_vertex_transform
// Fixed-point 3x4 affine transform of (x, y, z, 1) with a writable matrix.
// ----------------------------------------------------------------------------
// Pipeline: products, row sum, then scale and saturate are registered in turn
// before rsp_valid rises; a stage holds its data while the next cannot take it.
// Throughput: one transaction per cycle while rsp_stall is low, set by the
// three row lanes of three multipliers each; write commands give no result.
// Reset: synchronous, clears the matrix to zero and empties the pipeline.
module affine_vertex_transform import avt_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   mrow_type matrix_ff [ROWS];
   logic     v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic     rdy1, rdy2, rdy3;
   logic     accept, xform, wr_en;
   lane_ctrl_type           ctrl;
   logic signed [SUM_W-1:0] sum [ROWS];

   // a stage may take new data when it is empty or its content moves on
   assign rdy3 = !v3_ff || !rsp_stall;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign req_stall = !rdy1;
   assign accept    = req_valid && rdy1;
   assign xform     = accept && (req_payload.command == CMD_TRANSFORM);
   assign wr_en     = accept && (req_payload.command == CMD_WRITE)
                      && (req_payload.row != 2'd3);

   assign ctrl.prod_load = xform;
   assign ctrl.sum_load  = v1_ff && rdy2;

   assign v1_in = rdy1 ? xform : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? v2_ff : v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         for (int r = 0; r < ROWS; r++) begin
            matrix_ff[r] <= '0;
         end
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         if (wr_en) begin
            matrix_ff[req_payload.row][req_payload.column] <= req_payload.element_value;
         end
      end
   end

   for (genvar r = 0; r < ROWS; r++) begin : g_lane
      avt_lane #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock (clock),
         .ctrl  (ctrl),
         .mrow  (matrix_ff[r]),
         .x_in  (req_payload.x_in),
         .y_in  (req_payload.y_in),
         .z_in  (req_payload.z_in),
         .sum   (sum[r])
      );
   end

   avt_merge #(
      .FRAC_BITS (FRAC_BITS)
   ) u_merge (
      .clock (clock),
      .load  (v2_ff && rdy3),
      .sum   (sum),
      .rsp   (rsp_payload)
   );

   assign rsp_valid = v3_ff;

   // a write lands in the addressed element
   a_write_lands: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> matrix_ff[$past(req_payload.row)][$past(req_payload.column)]
                == $past(req_payload.element_value))
      else $error("matrix write lost");

   // write transactions never occupy the pipeline
   a_write_no_item: assert property (@(posedge clock) disable iff (reset)
      (accept && req_payload.command == CMD_WRITE) |=> !v1_ff)
      else $error("write entered pipeline");

   // input only held off when every stage is full
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff && rsp_stall))
      else $error("stall with a bubble in the pipeline");

endmodule
